>>> rtl/b64se_pkg.sv
// shared types, constants and the character table of the base64 stream encoder
// no dependencies
package b64se_pkg;

	localparam int unsigned CharW    = 7;
	localparam int unsigned CharsMax = 4;
	localparam int unsigned QDepth   = 2;
	localparam int unsigned QPtrW    = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int unsigned QCntW    = $clog2(QDepth + 1);

	localparam logic [CharW-1:0] PadChar = 7'd61;

	// position within the current three-byte group
	typedef enum logic [2:0] {
		PH_0 = 3'b001,
		PH_1 = 3'b010,
		PH_2 = 3'b100
	} phase_t;

	// one classified byte: the characters it produces and how many
	typedef struct packed {
		logic [CharsMax-1:0][CharW-1:0] chars;
		logic [1:0]                     n_m1;
		logic                           eom;
	} job_t;

	// six-bit group to alphabet character
	function automatic logic [CharW-1:0] sextet_char(input logic [5:0] v);
		logic [CharW-1:0] r;
		priority if (v < 6'd26) r = 7'd65 + {1'b0, v};
		else if (v < 6'd52) r = 7'd97 + {1'b0, v} - 7'd26;
		else if (v < 6'd62) r = 7'd48 + {1'b0, v} - 7'd52;
		else if (v == 6'd62) r = 7'd43;
		else r = 7'd47;
		return r;
	endfunction

endpackage

>>> rtl/b64se_front.sv
// front end: takes bytes, tracks the group phase and leftover bits,
// and builds a job of up to four characters; uses b64se_pkg
module b64se_front import b64se_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] data_byte,
	input  logic       end_of_message,
	output job_t       job,
	output phase_t     phase
);

	phase_t     phase_q;
	logic [3:0] left_q;

	always_comb begin
		job.chars = '0;
		job.n_m1  = 2'd0;
		job.eom   = end_of_message;
		unique case (phase_q)
			PH_1: begin
				job.chars[0] = sextet_char({left_q[1:0], data_byte[7:4]});
				if (end_of_message) begin
					job.chars[1] = sextet_char({data_byte[3:0], 2'b00});
					job.chars[2] = PadChar;
					job.n_m1     = 2'd2;
				end
			end
			PH_2: begin
				job.chars[0] = sextet_char({left_q[3:0], data_byte[7:6]});
				job.chars[1] = sextet_char(data_byte[5:0]);
				job.n_m1     = 2'd1;
			end
			default: begin
				job.chars[0] = sextet_char(data_byte[7:2]);
				if (end_of_message) begin
					job.chars[1] = sextet_char({data_byte[1:0], 4'b0000});
					job.chars[2] = PadChar;
					job.chars[3] = PadChar;
					job.n_m1     = 2'd3;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_0;
			left_q  <= 4'd0;
		end else if (take) begin
			if (end_of_message) begin
				phase_q <= PH_0;
				left_q  <= 4'd0;
			end else begin
				unique case (phase_q)
					PH_1: begin
						phase_q <= PH_2;
						left_q  <= data_byte[3:0];
					end
					PH_2: begin
						phase_q <= PH_0;
						left_q  <= 4'd0;
					end
					default: begin
						phase_q <= PH_1;
						left_q  <= {2'b00, data_byte[1:0]};
					end
				endcase
			end
		end
	end

	assign phase = phase_q;

endmodule

>>> rtl/b64se_queue.sv
// short job queue between front and back end
// uses b64se_pkg
module b64se_queue import b64se_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  job_t             push_job,
	input  logic             pop,
	output job_t             head,
	output logic             full,
	output logic             empty,
	output logic [QCntW-1:0] count
);

	job_t             mem_q [QDepth];
	logic [QPtrW-1:0] wr_q;
	logic [QPtrW-1:0] rd_q;
	logic [QCntW-1:0] cnt_q;

	function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
		logic [QPtrW-1:0] r;
		if (p == QPtrW'(QDepth - 1)) r = '0;
		else r = p + QPtrW'(1);
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ptr_inc(wr_q);
			if (pop) rd_q <= ptr_inc(rd_q);
			if (push && !pop) cnt_q <= cnt_q + QCntW'(1);
			else if (pop && !push) cnt_q <= cnt_q - QCntW'(1);
		end
	end

	assign head  = mem_q[rd_q];
	assign full  = (cnt_q == QCntW'(QDepth));
	assign empty = (cnt_q == '0);
	assign count = cnt_q;

endmodule

>>> rtl/b64se_back.sv
// back end: walks the characters of the head job into the output register
// uses b64se_pkg
module b64se_back import b64se_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  job_t             head,
	input  logic             head_valid,
	output logic             pop,
	output logic             char_valid,
	input  logic             char_stall,
	output logic [CharW-1:0] out_char,
	output logic             last_char
);

	logic [1:0]       idx_q;
	logic             valid_q;
	logic [CharW-1:0] char_q;
	logic             last_q;
	logic             load;
	logic             at_end;

	assign load   = !valid_q || !char_stall;
	assign at_end = (idx_q == head.n_m1);
	assign pop    = load && head_valid && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			char_q <= head.chars[idx_q];
			last_q <= head.eom && at_end;
		end
	end

	assign char_valid = valid_q;
	assign out_char   = char_q;
	assign last_char  = last_q;

endmodule

>>> rtl/base64_stream_encoder.sv
// base64 stream encoder top level: front end, job queue and back end
// uses b64se_pkg, b64se_front, b64se_queue, b64se_back
// One byte per item; end_of_message marks the last byte of a message. Each
// byte produces one or two characters, and the last byte of a message two to
// four, the final one with last_char set and the output padded with '=' to a
// multiple of four. A byte is taken whenever the two-entry job queue has
// room; the back end sends one character per cycle while char_stall is low,
// so throughput is set by the output: 4 characters per 3 bytes in a message.
// The first character of a byte is written into the job queue and then into
// the output register before it appears.
module base64_stream_encoder import b64se_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  logic [7:0]       data_byte,
	input  logic             end_of_message,
	output logic             char_valid,
	input  logic             char_stall,
	output logic [CharW-1:0] out_char,
	output logic             last_char
);

	job_t             new_job;
	job_t             head;
	phase_t           phase;
	logic             take;
	logic             pop;
	logic             full;
	logic             empty;
	logic [QCntW-1:0] count;

	assign item_stall = full;
	assign take       = item_valid && !full;

	b64se_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.job            (new_job),
		.phase          (phase)
	);

	b64se_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take),
		.push_job (new_job),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty),
		.count    (count)
	);

	b64se_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!empty),
		.pop        (pop),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.out_char   (out_char),
		.last_char  (last_char)
	);

`ifndef ASSERT_OFF
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= QCntW'(QDepth))
		else $error("job queue count out of range");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty job queue");

	a_eom_resets_phase: assert property (@(posedge clk) disable iff (!arst_n)
		take && end_of_message |=> phase == PH_0)
		else $error("group phase not cleared after last byte");

	a_pad_not_first: assert property (@(posedge clk) disable iff (!arst_n)
		take && !end_of_message |-> new_job.n_m1 != 2'd2 && new_job.n_m1 != 2'd3)
		else $error("padding job built for a byte inside a message");
`endif

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench for base64_stream_encoder: directed and random messages,
// random idling on both handshakes, expected characters worked out per accepted item
// depends on b64se_pkg and the base64_stream_encoder rtl
module testbench;
	import b64se_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [8*64-1:0] Digits =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	localparam int unsigned RandomBytes = 95;
	localparam int unsigned MaxGap      = 13;

	typedef struct {
		logic [CharW-1:0] ch;
		logic             last;
	} enc_char_t;

	// tracks the encoder's group state and the characters still owed
	class encoded_char_board;
		phase_t          phase;
		logic [3:0]      left;
		enc_char_t       chars_due[$];
		int unsigned     errors;
		int unsigned     checked;

		function new();
			phase   = PH_0;
			left    = 4'd0;
			errors  = 0;
			checked = 0;
		endfunction

		function logic [CharW-1:0] digit(logic [5:0] v);
			logic [7:0] c;
			c = Digits[8*(63-v) +: 8];
			return c[CharW-1:0];
		endfunction

		function void owe(logic [CharW-1:0] ch, logic last);
			enc_char_t e;
			e.ch   = ch;
			e.last = last;
			chars_due = {chars_due, e};
		endfunction

		function void take_byte(logic [7:0] b, logic eom);
			case (phase)
				PH_1: begin
					owe(digit({left[1:0], b[7:4]}), 1'b0);
					if (eom) begin
						owe(digit({b[3:0], 2'b00}), 1'b0);
						owe(PadChar, 1'b1);
					end else begin
						left  = b[3:0];
						phase = PH_2;
					end
				end
				PH_2: begin
					owe(digit({left, b[7:6]}), 1'b0);
					owe(digit(b[5:0]), eom);
					left  = 4'd0;
					phase = PH_0;
				end
				default: begin
					owe(digit(b[7:2]), 1'b0);
					if (eom) begin
						owe(digit({b[1:0], 4'b0000}), 1'b0);
						owe(PadChar, 1'b0);
						owe(PadChar, 1'b1);
					end else begin
						left  = {2'b00, b[1:0]};
						phase = PH_1;
					end
				end
			endcase
			if (eom) begin
				left  = 4'd0;
				phase = PH_0;
			end
		endfunction

		task report_mismatch(string what);
			$display("%0t ns: mismatch: %s", $realtime, what);
			errors++;
		endtask

		task check_char(logic [CharW-1:0] ch, logic last);
			enc_char_t e;
			if (chars_due.size() == 0) begin
				report_mismatch($sformatf("unexpected char 0x%02h last=%0b", ch, last));
				return;
			end
			e = chars_due.pop_front();
			checked++;
			if (ch !== e.ch)
				report_mismatch($sformatf("out_char 0x%02h, want 0x%02h", ch, e.ch));
			if (last !== e.last)
				report_mismatch($sformatf("last_char %0b, want %0b", last, e.last));
		endtask

		function int unsigned pending();
			return chars_due.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	logic [7:0]       data_byte = 8'd0;
	logic             end_of_message = 1'b0;
	logic             char_valid;
	logic             char_stall = 1'b0;
	logic [CharW-1:0] out_char;
	logic             last_char;

	encoded_char_board board = new();
	bit                tx_calm = 1'b0;
	bit                rx_calm = 1'b0;
	int unsigned       bytes_sent = 0;
	int unsigned       msgs_sent = 0;

	base64_stream_encoder uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.char_valid     (char_valid),
		.char_stall     (char_stall),
		.out_char       (out_char),
		.last_char      (last_char)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned draw_gap(bit calm);
		return calm ? 0 : $urandom_range(0, MaxGap);
	endfunction

	// valid stays high from one item to the next when the gap is zero
	task automatic send_byte(logic [7:0] b, logic eom);
		int unsigned gap;
		gap = draw_gap(tx_calm);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid     <= 1'b1;
		data_byte      <= b;
		end_of_message <= eom;
		do @(posedge clk); while (item_stall !== 1'b0);
		board.take_byte(b, eom);
		bytes_sent++;
		if (eom)
			msgs_sent++;
	endtask

	// hold off the sender until every owed character has come out
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
	endtask

	// receiving side: random stall before each item
	initial begin
		int unsigned gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap(rx_calm);
			if (gap > 0) begin
				char_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			char_stall <= 1'b0;
			do @(posedge clk); while (char_valid !== 1'b1);
			board.check_char(out_char, last_char);
		end
	end

	initial begin
		#2ms;
		$display("timeout with %0d chars still owed", board.pending());
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		// {end_of_message, data_byte}: lone bytes, all group endings, '+' and '/'
		logic [8:0]  directed_items[] = '{
			9'h100, 9'h1FF, 9'h0FB, 9'h1FF, 9'h080, 9'h101,
			9'h04D, 9'h061, 9'h16E, 9'h0FF, 9'h0FF, 9'h1FF,
			9'h000, 9'h000, 9'h100, 9'h0F8, 9'h03E, 9'h07F,
			9'h055, 9'h1AA, 9'h001, 9'h002, 9'h004, 9'h008, 9'h140
		};
		int unsigned len;
		bit          drained_mid;

		drained_mid = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_items[i])
			send_byte(directed_items[i][7:0], directed_items[i][8]);
		drain();

		while (bytes_sent < RandomBytes + directed_items.size()) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			// mostly short messages, now and then a long one
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 7);
			for (int unsigned i = 0; i < len; i++)
				send_byte(8'($urandom_range(0, 255)), i == len - 1);
			if (!drained_mid && bytes_sent > directed_items.size() + RandomBytes / 2) begin
				drained_mid = 1'b1;
				drain();
			end
		end
		drain();
		repeat (20) @(posedge clk);

		$display("sent %0d bytes in %0d messages, checked %0d chars under random stalls",
			bytes_sent, msgs_sent, board.checked);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches, %0d chars never seen", board.errors, board.pending());
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
